FILE: rtl/swhc_pkg.sv
// ----------------------------------------------------------------------------
// swhc_pkg: shared definitions for the sliding window hit counter
// Field widths, saturation limits, action codes and sequencer states.
// ----------------------------------------------------------------------------
package swhc_pkg;

  localparam int TIME_W   = 31;
  localparam int COUNT_W  = 16;
  localparam int TOTAL_W  = 25;

  localparam int WINDOW_DEF = 300;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Action codes carried on the input channel
  localparam logic ACT_HIT   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_QUOT   = 9'b000000100,
    ST_SCALE  = 9'b000001000,
    ST_REM    = 9'b000010000,
    ST_HREAD  = 9'b000100000,
    ST_HWRITE = 9'b001000000,
    ST_QSCAN  = 9'b010000000,
    ST_QDONE  = 9'b100000000
  } state_t;

endpackage

FILE: rtl/sliding_window_hit_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_hit_counter: event rate counter over a sliding time window
// Ring of WINDOW time-tagged buckets in one memory, worked by a small
// sequencer around one shared subtract/compare unit and one adder.
// ----------------------------------------------------------------------------
// Usage and timing: each input transaction is a hit (action 0) or a query
// (action 1) with a non-decreasing seconds timestamp. A hit bumps the bucket
// at event_time mod WINDOW (retagging it when it holds another time) and
// returns nothing; a query returns the saturated sum of all buckets whose tag
// lies in [event_time - WINDOW + 1, event_time]. After reset the block clears
// the bucket memory with in_ready low. The block works on one item at a time:
// a hit is accepted, then takes three steps for the remainder (reciprocal
// multiply for the quotient, scale it back by WINDOW, subtract through the
// shared subtractor), then one memory read and one write; a query is
// accepted, then walks the buckets over the single memory read port (one
// bucket per cycle into one accumulator), accumulates the last read, makes
// an end check and loads the output once the output register is free. A
// finished query total sits in the output register, so hits keep flowing
// while it waits to be taken.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter #(
  parameter int WINDOW = swhc_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic [swhc_pkg::TIME_W-1:0]  in_event_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swhc_pkg::TOTAL_W-1:0] out_hit_total
);

  // Bucket address width, and index width wide enough to hold WINDOW itself
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int IW = AW + 1;
  localparam int TW = swhc_pkg::TIME_W;
  localparam int CW = swhc_pkg::COUNT_W;
  localparam int SW = swhc_pkg::TOTAL_W;
  localparam int EW = TW + CW;

  // Reciprocal of WINDOW, rounded up, scaled by 2^RK: exact for any time
  localparam int            RK     = TW + $clog2(WINDOW);
  localparam logic [31:0]   RECIP  =
    32'(((64'd1 << RK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [IW-1:0] WIN_I   = IW'(WINDOW);
  localparam logic [IW-1:0] WIN_M1  = IW'(WINDOW - 1);
  localparam logic [31:0]   WIN_32  = 32'(WINDOW);
  localparam logic [TW-1:0] WIN_T   = TW'(WINDOW);

  swhc_pkg::state_t state_r, state_nxt;

  logic [TW-1:0]               now_r, now_nxt;
  logic [TW-1:0]               quot_r, quot_nxt;
  logic [TW-1:0]               qmul_r, qmul_nxt;
  logic [AW-1:0]               rem_r, rem_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [SW-1:0]               total_r, total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [SW-1:0]               out_total_r, out_total_nxt;

  // Bucket memory: {tag, count} per entry
  logic [EW-1:0] bucket_mem_r [WINDOW];
  logic [EW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [TW-1:0] rd_tag;
  logic [CW-1:0] rd_cnt;

  // Shared subtract/compare unit and the quotient multiplier
  logic [31:0]    sub_a, sub_b, sub_diff;
  logic           sub_borrow;
  logic [TW+31:0] recip_prod;

  logic          in_win;
  logic [SW:0]   acc_sum;
  logic          in_fire;

  assign rd_tag  = rd_data_r[EW-1:CW];
  assign rd_cnt  = rd_data_r[CW-1:0];
  assign in_fire = in_valid && in_ready;

  // Quotient estimate: (now * RECIP) >> RK equals now / WINDOW exactly
  assign recip_prod = (TW + 32)'(now_r) * (TW + 32)'(RECIP);

  // Remainder step subtracts quotient * WINDOW, the scan subtracts the tag
  assign sub_a = {1'b0, now_r};
  assign sub_b = (state_r == swhc_pkg::ST_REM) ? {1'b0, qmul_r} : {1'b0, rd_tag};

  assign sub_diff   = sub_a - sub_b;
  assign sub_borrow = sub_diff[31];

  // Bucket counts toward the query when now - WINDOW < tag <= now
  assign in_win  = !sub_borrow && (sub_diff < WIN_32);
  assign acc_sum = {1'b0, total_r} + (SW + 1)'(in_win ? rd_cnt : '0);

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    quot_nxt      = quot_r;
    qmul_nxt      = qmul_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    mem_we        = 1'b0;
    mem_waddr     = rem_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = rem_r;
    in_ready      = 1'b0;

    // Drop the held result once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      swhc_pkg::ST_CLEAR: begin
        // Zero one bucket per cycle after reset
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = '0;
        if (idx_r == WIN_M1) begin
          idx_nxt   = '0;
          state_nxt = swhc_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      swhc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          now_nxt   = in_event_time;
          rem_nxt   = '0;
          idx_nxt   = '0;
          total_nxt = '0;
          if (in_action == swhc_pkg::ACT_QUERY) begin
            state_nxt = swhc_pkg::ST_QSCAN;
          end else begin
            state_nxt = swhc_pkg::ST_QUOT;
          end
        end
      end
      swhc_pkg::ST_QUOT: begin
        // Hold the quotient of event_time by WINDOW
        quot_nxt  = TW'(recip_prod >> RK);
        state_nxt = swhc_pkg::ST_SCALE;
      end
      swhc_pkg::ST_SCALE: begin
        qmul_nxt  = quot_r * WIN_T;
        state_nxt = swhc_pkg::ST_REM;
      end
      swhc_pkg::ST_REM: begin
        // What is left after the whole windows is the bucket address
        rem_nxt   = sub_diff[AW-1:0];
        state_nxt = swhc_pkg::ST_HREAD;
      end
      swhc_pkg::ST_HREAD: begin
        mem_re    = 1'b1;
        mem_raddr = rem_r;
        state_nxt = swhc_pkg::ST_HWRITE;
      end
      swhc_pkg::ST_HWRITE: begin
        // Retag a stale bucket, else advance its count with saturation
        mem_we    = 1'b1;
        mem_waddr = rem_r;
        if (rd_tag != now_r) begin
          mem_wdata = {now_r, CW'(1)};
        end else if (rd_cnt != swhc_pkg::COUNT_MAX) begin
          mem_wdata = {now_r, rd_cnt + CW'(1)};
        end else begin
          mem_wdata = {now_r, rd_cnt};
        end
        state_nxt = swhc_pkg::ST_IDLE;
      end
      swhc_pkg::ST_QSCAN: begin
        // Issue one read per cycle, accumulate the one issued last cycle
        if (idx_r != WIN_I) begin
          mem_re     = 1'b1;
          mem_raddr  = idx_r[AW-1:0];
          idx_nxt    = idx_r + IW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          total_nxt = acc_sum[SW] ? swhc_pkg::TOTAL_MAX : acc_sum[SW-1:0];
        end
        if ((idx_r == WIN_I) && !rd_vld_r) begin
          state_nxt = swhc_pkg::ST_QDONE;
        end
      end
      swhc_pkg::ST_QDONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = swhc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swhc_pkg::ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swhc_pkg::ST_CLEAR;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    quot_r      <= quot_nxt;
    qmul_r      <= qmul_nxt;
    rem_r       <= rem_nxt;
    total_r     <= total_nxt;
    out_total_r <= out_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bucket_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= bucket_mem_r[mem_raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit_total = out_total_r;

`ifndef SYNTHESIS
  // A hit never creates a result transaction
  a_hit_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_action == swhc_pkg::ACT_HIT) && !out_valid_r) |=> !out_valid_r)
    else $error("hit produced a result");

  // The remainder is a valid bucket address by the time it is used
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swhc_pkg::ST_HREAD) |-> (32'(rem_r) < WIN_32))
    else $error("remainder out of range");

  // The scan index never passes the window size
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swhc_pkg::ST_QSCAN) |-> (idx_r <= WIN_I))
    else $error("scan index past window");

  // A pending scan read only exists inside the scan
  a_rd_pending: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == swhc_pkg::ST_QSCAN))
    else $error("scan read pending outside scan");
`endif

endmodule
